// ----- hw/rtl/stsolv_pkg.sv -----
// ----------------------------------------------------------------------------
// stsolv_pkg
// Shared constants, types and helpers of the simplex tableau solver.
// ----------------------------------------------------------------------------
`default_nettype none

package stsolv_pkg;

  localparam int MAX_CONSTRAINTS = 16;
  localparam int MAX_VARS        = 16;
  localparam int VALUE_WIDTH     = 48;
  localparam int FRAC_BITS       = 16;
  localparam int NCOLS           = MAX_VARS + 1;
  localparam int DEPTH           = (MAX_CONSTRAINTS + 1) * NCOLS;
  localparam int ADDR_W          = $clog2(DEPTH);
  localparam int CNT_W           = 5;
  localparam int RIDX_W          = $clog2(MAX_CONSTRAINTS);
  localparam int CIDX_W          = $clog2(MAX_VARS);
  localparam int LBL_W           = 6;
  localparam int PC_W            = 6;
  localparam int LPOS_W          = ADDR_W;
  localparam int STEP_W          = 7;
  localparam int MUL_STEPS       = VALUE_WIDTH;
  localparam int DIV_STEPS       = 2 * VALUE_WIDTH;
  localparam int CTRL_STATES     = 46;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [VALUE_WIDTH-1:0]        umag_t;

  localparam umag_t  ONE  = umag_t'(1) << FRAC_BITS;
  localparam value_t VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam logic [1:0] STATUS_OPTIMAL   = 2'd0;
  localparam logic [1:0] STATUS_UNBOUNDED = 2'd1;
  localparam logic [1:0] STATUS_LIMIT     = 2'd2;

  typedef enum logic [1:0] {
    REG_NUM_CONSTRAINTS = 2'd0,
    REG_NUM_VARS        = 2'd1,
    REG_MAX_PIVOTS      = 2'd2,
    REG_UNUSED          = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {RS_I, RS_R, RS_M} rsel_t;
  typedef enum logic [1:0] {CS_J, CS_C, CS_N} csel_t;
  typedef enum logic [2:0] {MD_RATIO, MD_UPDATE, MD_COL, MD_ROW, MD_PIVOT} md_mode_t;
  typedef enum logic {WS_SUB, WS_QUOT} wsel_t;
  typedef enum logic [1:0] {OK_VAR, OK_Z, OK_UNB, OK_LIM} out_kind_t;

  typedef struct packed {
    logic      accept_en;
    rsel_t     rsel;
    csel_t     csel;
    logic      sol_we;
    wsel_t     wsel;
    logic      latch_a;
    logic      latch_p;
    logic      md_start;
    md_mode_t  md_mode;
    logic      ent_clr;
    logic      ent_upd;
    logic      rat_clr;
    logic      rat_upd;
    logic      i_clr;
    logic      i_inc;
    logic      j_clr;
    logic      j_inc;
    logic      pc_clr;
    logic      pc_inc;
    logic      lbl_init;
    logic      lbl_swap;
    logic      opt_clr;
    logic      opt_latch;
    logic      out_load;
    out_kind_t out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic accept;
    logic last_in;
    logic j_last;
    logic j_end;
    logic i_last;
    logic i_end;
    logic i_is_r;
    logic j_is_c;
    logic rd_pos;
    logic best_neg;
    logic found;
    logic pc_hit;
    logic md_done;
    logic lbl_match;
    logic out_free;
  } dp_stat_t;

  function automatic umag_t mag(input value_t v);
    mag = v[VALUE_WIDTH-1] ? umag_t'(-v) : umag_t'(v);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/stsolv_ram.sv -----
// ----------------------------------------------------------------------------
// stsolv_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module stsolv_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 289
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stsolv_muldiv.sv -----
// ----------------------------------------------------------------------------
// stsolv_muldiv
// Serial (a*b)/d on magnitudes: shift-add multiply, restoring divide,
// truncation, saturation and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module stsolv_muldiv (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire stsolv_pkg::umag_t    num,
  input  wire stsolv_pkg::umag_t    mul,
  input  wire stsolv_pkg::umag_t    den,
  input  wire logic                 neg,
  output      logic                 done,
  output      stsolv_pkg::value_t   q
);

  localparam int W = stsolv_pkg::VALUE_WIDTH;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_MUL  = 4'b0010,
    M_DIV  = 4'b0100,
    M_FIN  = 4'b1000
  } mstate_t;

  mstate_t                          state;
  logic [stsolv_pkg::STEP_W-1:0]    cnt;
  stsolv_pkg::umag_t                num_r;
  stsolv_pkg::umag_t                mul_r;
  stsolv_pkg::umag_t                den_r;
  logic                             neg_r;
  logic [2*W-1:0]                   prod;
  stsolv_pkg::umag_t                rem;
  stsolv_pkg::umag_t                quo;
  logic                             ovf;

  logic [W:0]           rem_sh;
  logic                 ge;
  stsolv_pkg::umag_t    lim;
  stsolv_pkg::umag_t    qs;

  function automatic stsolv_pkg::umag_t umag_mask();
    umag_mask = {1'b0, {(W-1){1'b1}}};
  endfunction

  assign rem_sh = {rem, prod[2*W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign lim    = neg_r ? (stsolv_pkg::umag_t'(1) << (W - 1))
                        : umag_mask();
  assign qs     = (ovf || quo > lim) ? lim : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            num_r <= num;
            mul_r <= mul;
            den_r <= den;
            neg_r <= neg;
            prod  <= '0;
            cnt   <= '0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          prod  <= (prod << 1) + (mul_r[W-1] ? {{W{1'b0}}, num_r} : {(2*W){1'b0}});
          mul_r <= mul_r << 1;
          cnt   <= cnt + 1'b1;
          if (cnt == stsolv_pkg::STEP_W'(stsolv_pkg::MUL_STEPS - 1)) begin
            cnt   <= '0;
            rem   <= '0;
            quo   <= '0;
            ovf   <= 1'b0;
            state <= M_DIV;
          end
        end
        M_DIV: begin
          prod <= prod << 1;
          rem  <= ge ? W'(rem_sh - {1'b0, den_r}) : W'(rem_sh);
          ovf  <= ovf | quo[W-1];
          quo  <= {quo[W-2:0], ge};
          cnt  <= cnt + 1'b1;
          if (cnt == stsolv_pkg::STEP_W'(stsolv_pkg::DIV_STEPS - 1)) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          q     <= neg_r ? stsolv_pkg::value_t'(-qs) : stsolv_pkg::value_t'(qs);
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stsolv_dp.sv -----
// ----------------------------------------------------------------------------
// stsolv_dp
// Solver datapath: tableau memory, loader, scan registers, labels,
// multiply-divide unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stsolv_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire stsolv_pkg::dp_cmd_t           cmd,
  output      stsolv_pkg::dp_stat_t          st,
  input  wire logic [stsolv_pkg::CNT_W-1:0]  m,
  input  wire logic [stsolv_pkg::CNT_W-1:0]  n,
  input  wire logic [stsolv_pkg::PC_W-1:0]   maxp,
  input  wire logic                          nv_wr,
  input  wire logic                          entry_valid,
  output      logic                          entry_stall,
  input  wire logic signed [47:0]            entry_value,
  input  wire logic                          last_entry,
  output      logic                          result_valid,
  input  wire logic                          result_stall,
  output      logic [1:0]                    status,
  output      logic [4:0]                    var_index,
  output      logic signed [47:0]            var_value,
  output      logic                          last_result
);

  localparam int AW = stsolv_pkg::ADDR_W;
  localparam int VW = stsolv_pkg::VALUE_WIDTH;

  // loader
  logic [stsolv_pkg::LPOS_W-1:0] load_pos;
  logic [stsolv_pkg::LPOS_W-1:0] load_row;
  logic [stsolv_pkg::LPOS_W-1:0] load_col;
  logic                          aligning;
  logic                          accept;
  logic                          load_ok;
  logic [stsolv_pkg::LPOS_W-1:0] width_x;
  logic [AW-1:0]                 load_addr;

  // solver registers
  logic [stsolv_pkg::CNT_W-1:0]  i_cnt;
  logic [stsolv_pkg::CNT_W-1:0]  j_cnt;
  logic [stsolv_pkg::RIDX_W-1:0] lr;
  logic [stsolv_pkg::CIDX_W-1:0] ec;
  stsolv_pkg::value_t            best;
  stsolv_pkg::value_t            bestr;
  logic                          found;
  stsolv_pkg::value_t            a_reg;
  stsolv_pkg::value_t            p_reg;
  stsolv_pkg::value_t            opt_val;
  logic [stsolv_pkg::PC_W-1:0]   pivot_count;
  logic [stsolv_pkg::LBL_W-1:0]  row_labels [stsolv_pkg::MAX_CONSTRAINTS];
  logic [stsolv_pkg::LBL_W-1:0]  column_labels [stsolv_pkg::MAX_VARS];

  // memory and arithmetic
  stsolv_pkg::value_t            rd_data;
  logic [stsolv_pkg::CNT_W-1:0]  row_sel;
  logic [stsolv_pkg::CNT_W-1:0]  col_sel;
  logic [AW-1:0]                 sol_addr;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  stsolv_pkg::value_t            ram_wdata;
  stsolv_pkg::value_t            sub_val;
  logic signed [VW:0]            diff;
  stsolv_pkg::umag_t             md_num;
  stsolv_pkg::umag_t             md_mul;
  stsolv_pkg::umag_t             md_den;
  logic                          md_neg;
  logic                          md_done;
  stsolv_pkg::value_t            md_q;
  logic                          out_free;
  logic [stsolv_pkg::RIDX_W-1:0] rl_idx;

  assign accept      = entry_valid && cmd.accept_en && !aligning;
  assign entry_stall = !(cmd.accept_en && !aligning);
  assign width_x     = stsolv_pkg::LPOS_W'(n) + 1'b1;
  assign load_ok     = load_row <= stsolv_pkg::LPOS_W'(m);
  assign load_addr   = AW'(load_row * stsolv_pkg::LPOS_W'(stsolv_pkg::NCOLS) + load_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      load_row <= '0;
      load_col <= '0;
      aligning <= 1'b0;
    end else if (nv_wr) begin
      load_row <= '0;
      load_col <= load_pos;
      aligning <= 1'b1;
    end else if (aligning) begin
      if (load_col >= width_x) begin
        load_col <= load_col - width_x;
        load_row <= load_row + 1'b1;
      end else begin
        aligning <= 1'b0;
      end
    end else if (accept) begin
      if (last_entry) begin
        load_pos <= '0;
        load_row <= '0;
        load_col <= '0;
      end else if (load_ok) begin
        load_pos <= load_pos + 1'b1;
        if (load_col == stsolv_pkg::LPOS_W'(n)) begin
          load_col <= '0;
          load_row <= load_row + 1'b1;
        end else begin
          load_col <= load_col + 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (cmd.rsel)
      stsolv_pkg::RS_R: row_sel = stsolv_pkg::CNT_W'(lr);
      stsolv_pkg::RS_M: row_sel = m;
      default:          row_sel = i_cnt;
    endcase
    case (cmd.csel)
      stsolv_pkg::CS_C: col_sel = stsolv_pkg::CNT_W'(ec);
      stsolv_pkg::CS_N: col_sel = n;
      default:          col_sel = j_cnt;
    endcase
  end

  assign sol_addr = AW'(row_sel) * AW'(stsolv_pkg::NCOLS) + AW'(col_sel);

  assign diff    = {rd_data[VW-1], rd_data} - {md_q[VW-1], md_q};
  assign sub_val = (diff[VW] != diff[VW-1])
                   ? (diff[VW] ? stsolv_pkg::VMIN : stsolv_pkg::VMAX)
                   : stsolv_pkg::value_t'(diff[VW-1:0]);

  always_comb begin
    if (accept) begin
      ram_we    = load_ok;
      ram_waddr = load_addr;
      ram_wdata = entry_value;
    end else begin
      ram_we    = cmd.sol_we;
      ram_waddr = sol_addr;
      ram_wdata = (cmd.wsel == stsolv_pkg::WS_SUB) ? sub_val : md_q;
    end
  end

  stsolv_ram #(
    .WIDTH (VW),
    .DEPTH (stsolv_pkg::DEPTH)
  ) u_tableau (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (sol_addr),
    .rdata (rd_data)
  );

  always_comb begin
    md_den = stsolv_pkg::umag_t'(p_reg);
    case (cmd.md_mode)
      stsolv_pkg::MD_RATIO: begin
        md_num = stsolv_pkg::mag(rd_data);
        md_mul = stsolv_pkg::ONE;
        md_den = stsolv_pkg::umag_t'(a_reg);
        md_neg = rd_data[VW-1];
      end
      stsolv_pkg::MD_UPDATE: begin
        md_num = stsolv_pkg::mag(a_reg);
        md_mul = stsolv_pkg::mag(rd_data);
        md_neg = a_reg[VW-1] ^ rd_data[VW-1];
      end
      stsolv_pkg::MD_COL: begin
        md_num = stsolv_pkg::mag(rd_data);
        md_mul = stsolv_pkg::ONE;
        md_neg = rd_data > 0;
      end
      stsolv_pkg::MD_ROW: begin
        md_num = stsolv_pkg::mag(rd_data);
        md_mul = stsolv_pkg::ONE;
        md_neg = rd_data[VW-1];
      end
      default: begin
        md_num = stsolv_pkg::ONE;
        md_mul = stsolv_pkg::ONE;
        md_neg = 1'b0;
      end
    endcase
  end

  stsolv_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.md_start),
    .num   (md_num),
    .mul   (md_mul),
    .den   (md_den),
    .neg   (md_neg),
    .done  (md_done),
    .q     (md_q)
  );

  assign rl_idx = cmd.lbl_swap ? lr : i_cnt[stsolv_pkg::RIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.lbl_init) begin
      for (int k = 0; k < stsolv_pkg::MAX_CONSTRAINTS; k++) begin
        row_labels[k] <= stsolv_pkg::LBL_W'(stsolv_pkg::MAX_VARS + k);
      end
      for (int k = 0; k < stsolv_pkg::MAX_VARS; k++) begin
        column_labels[k] <= stsolv_pkg::LBL_W'(k);
      end
    end else if (cmd.lbl_swap) begin
      row_labels[rl_idx] <= column_labels[ec];
      column_labels[ec]  <= row_labels[rl_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_cnt       <= '0;
      j_cnt       <= '0;
      found       <= 1'b0;
      pivot_count <= '0;
    end else begin
      if (cmd.i_clr) begin
        i_cnt <= '0;
      end else if (cmd.i_inc) begin
        i_cnt <= i_cnt + 1'b1;
      end
      if (cmd.j_clr || cmd.ent_clr) begin
        j_cnt <= '0;
      end else if (cmd.j_inc) begin
        j_cnt <= j_cnt + 1'b1;
      end
      if (cmd.rat_clr) begin
        found <= 1'b0;
      end else if (cmd.rat_upd && (!found || md_q <= bestr)) begin
        found <= 1'b1;
      end
      if (cmd.pc_clr) begin
        pivot_count <= '0;
      end else if (cmd.pc_inc) begin
        pivot_count <= pivot_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ent_clr) begin
      best <= '0;
      ec   <= '0;
    end else if (cmd.ent_upd && rd_data <= best) begin
      best <= rd_data;
      ec   <= j_cnt[stsolv_pkg::CIDX_W-1:0];
    end
    if (cmd.rat_upd && (!found || md_q <= bestr)) begin
      bestr <= md_q;
      lr    <= i_cnt[stsolv_pkg::RIDX_W-1:0];
    end
    if (cmd.latch_a) begin
      a_reg <= rd_data;
    end
    if (cmd.latch_p) begin
      p_reg <= rd_data;
    end
    if (cmd.opt_clr) begin
      opt_val <= '0;
    end else if (cmd.opt_latch) begin
      opt_val <= rd_data;
    end
  end

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        stsolv_pkg::OK_VAR: begin
          status      <= stsolv_pkg::STATUS_OPTIMAL;
          var_index   <= j_cnt;
          var_value   <= opt_val;
          last_result <= 1'b0;
        end
        stsolv_pkg::OK_Z: begin
          status      <= stsolv_pkg::STATUS_OPTIMAL;
          var_index   <= n;
          var_value   <= opt_val;
          last_result <= 1'b1;
        end
        stsolv_pkg::OK_UNB: begin
          status      <= stsolv_pkg::STATUS_UNBOUNDED;
          var_index   <= '0;
          var_value   <= '0;
          last_result <= 1'b1;
        end
        default: begin
          status      <= stsolv_pkg::STATUS_LIMIT;
          var_index   <= '0;
          var_value   <= '0;
          last_result <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    st.accept    = accept;
    st.last_in   = last_entry;
    st.j_last    = j_cnt == n - 1'b1;
    st.j_end     = j_cnt == n;
    st.i_last    = i_cnt == m - 1'b1;
    st.i_end     = i_cnt == m;
    st.i_is_r    = i_cnt == stsolv_pkg::CNT_W'(lr);
    st.j_is_c    = j_cnt == stsolv_pkg::CNT_W'(ec);
    st.rd_pos    = rd_data > 0;
    st.best_neg  = best[VW-1];
    st.found     = found;
    st.pc_hit    = pivot_count >= maxp;
    st.md_done   = md_done;
    st.lbl_match = row_labels[rl_idx] == stsolv_pkg::LBL_W'(j_cnt);
    st.out_free  = out_free;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stsolv_ctrl.sv -----
// ----------------------------------------------------------------------------
// stsolv_ctrl
// Solver sequencer: load, entering column scan, ratio test, pivot update,
// result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module stsolv_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire stsolv_pkg::dp_stat_t   st,
  output      stsolv_pkg::dp_cmd_t    cmd
);

  localparam int SW = stsolv_pkg::CTRL_STATES;

  typedef enum logic [SW-1:0] {
    S_IDLE     = SW'(1) << 0,
    S_START    = SW'(1) << 1,
    S_ENT_RD   = SW'(1) << 2,
    S_ENT_EV   = SW'(1) << 3,
    S_ENT_DONE = SW'(1) << 4,
    S_RAT_RDA  = SW'(1) << 5,
    S_RAT_EVA  = SW'(1) << 6,
    S_RAT_RDB  = SW'(1) << 7,
    S_RAT_EVB  = SW'(1) << 8,
    S_RAT_WAIT = SW'(1) << 9,
    S_RAT_NEXT = SW'(1) << 10,
    S_RAT_DONE = SW'(1) << 11,
    S_PV_RD    = SW'(1) << 12,
    S_PV_EV    = SW'(1) << 13,
    S_UP_CHK   = SW'(1) << 14,
    S_UP_RDA   = SW'(1) << 15,
    S_UP_EVA   = SW'(1) << 16,
    S_UP_RDB   = SW'(1) << 17,
    S_UP_EVB   = SW'(1) << 18,
    S_UP_WAIT  = SW'(1) << 19,
    S_UP_RDX   = SW'(1) << 20,
    S_UP_EVX   = SW'(1) << 21,
    S_UP_NEXT  = SW'(1) << 22,
    S_CO_CHK   = SW'(1) << 23,
    S_CO_RD    = SW'(1) << 24,
    S_CO_EV    = SW'(1) << 25,
    S_CO_WAIT  = SW'(1) << 26,
    S_CO_NEXT  = SW'(1) << 27,
    S_RW_CHK   = SW'(1) << 28,
    S_RW_RD    = SW'(1) << 29,
    S_RW_EV    = SW'(1) << 30,
    S_RW_WAIT  = SW'(1) << 31,
    S_RW_NEXT  = SW'(1) << 32,
    S_PC_GO    = SW'(1) << 33,
    S_PC_WAIT  = SW'(1) << 34,
    S_PC_CHK   = SW'(1) << 35,
    S_OPT_J    = SW'(1) << 36,
    S_OPT_CHK  = SW'(1) << 37,
    S_OPT_RD   = SW'(1) << 38,
    S_OPT_EV   = SW'(1) << 39,
    S_OPT_EMIT = SW'(1) << 40,
    S_Z_RD     = SW'(1) << 41,
    S_Z_EV     = SW'(1) << 42,
    S_Z_EMIT   = SW'(1) << 43,
    S_EMIT_UNB = SW'(1) << 44,
    S_EMIT_LIM = SW'(1) << 45
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rsel   = stsolv_pkg::RS_I;
    cmd.csel   = stsolv_pkg::CS_J;
    cmd.wsel   = stsolv_pkg::WS_QUOT;
    cmd.md_mode  = stsolv_pkg::MD_PIVOT;
    cmd.out_kind = stsolv_pkg::OK_VAR;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accept_en = 1'b1;
        if (st.accept && st.last_in) begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.lbl_init = 1'b1;
        cmd.pc_clr   = 1'b1;
        cmd.ent_clr  = 1'b1;
        state_next   = S_ENT_RD;
      end
      S_ENT_RD: begin
        cmd.rsel   = stsolv_pkg::RS_M;
        state_next = S_ENT_EV;
      end
      S_ENT_EV: begin
        cmd.ent_upd = 1'b1;
        if (st.j_last) begin
          state_next = S_ENT_DONE;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = S_ENT_RD;
        end
      end
      S_ENT_DONE: begin
        if (!st.best_neg) begin
          cmd.j_clr  = 1'b1;
          state_next = S_OPT_J;
        end else begin
          cmd.i_clr   = 1'b1;
          cmd.rat_clr = 1'b1;
          state_next  = S_RAT_RDA;
        end
      end
      S_RAT_RDA: begin
        cmd.csel   = stsolv_pkg::CS_C;
        state_next = S_RAT_EVA;
      end
      S_RAT_EVA: begin
        cmd.latch_a = 1'b1;
        state_next  = st.rd_pos ? S_RAT_RDB : S_RAT_NEXT;
      end
      S_RAT_RDB: begin
        cmd.csel   = stsolv_pkg::CS_N;
        state_next = S_RAT_EVB;
      end
      S_RAT_EVB: begin
        cmd.md_start = 1'b1;
        cmd.md_mode  = stsolv_pkg::MD_RATIO;
        state_next   = S_RAT_WAIT;
      end
      S_RAT_WAIT: begin
        if (st.md_done) begin
          cmd.rat_upd = 1'b1;
          state_next  = S_RAT_NEXT;
        end
      end
      S_RAT_NEXT: begin
        if (st.i_last) begin
          state_next = S_RAT_DONE;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_RAT_RDA;
        end
      end
      S_RAT_DONE: begin
        if (!st.found) begin
          state_next = S_EMIT_UNB;
        end else if (st.pc_hit) begin
          state_next = S_EMIT_LIM;
        end else begin
          state_next = S_PV_RD;
        end
      end
      S_PV_RD: begin
        cmd.rsel   = stsolv_pkg::RS_R;
        cmd.csel   = stsolv_pkg::CS_C;
        state_next = S_PV_EV;
      end
      S_PV_EV: begin
        cmd.latch_p = 1'b1;
        cmd.i_clr   = 1'b1;
        cmd.j_clr   = 1'b1;
        state_next  = S_UP_CHK;
      end
      S_UP_CHK: begin
        state_next = (st.i_is_r || st.j_is_c) ? S_UP_NEXT : S_UP_RDA;
      end
      S_UP_RDA: begin
        cmd.csel   = stsolv_pkg::CS_C;
        state_next = S_UP_EVA;
      end
      S_UP_EVA: begin
        cmd.latch_a = 1'b1;
        state_next  = S_UP_RDB;
      end
      S_UP_RDB: begin
        cmd.rsel   = stsolv_pkg::RS_R;
        state_next = S_UP_EVB;
      end
      S_UP_EVB: begin
        cmd.md_start = 1'b1;
        cmd.md_mode  = stsolv_pkg::MD_UPDATE;
        state_next   = S_UP_WAIT;
      end
      S_UP_WAIT: begin
        if (st.md_done) begin
          state_next = S_UP_RDX;
        end
      end
      S_UP_RDX: begin
        state_next = S_UP_EVX;
      end
      S_UP_EVX: begin
        cmd.sol_we = 1'b1;
        cmd.wsel   = stsolv_pkg::WS_SUB;
        state_next = S_UP_NEXT;
      end
      S_UP_NEXT: begin
        if (st.j_end) begin
          cmd.j_clr = 1'b1;
          if (st.i_end) begin
            cmd.i_clr  = 1'b1;
            state_next = S_CO_CHK;
          end else begin
            cmd.i_inc  = 1'b1;
            state_next = S_UP_CHK;
          end
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = S_UP_CHK;
        end
      end
      S_CO_CHK: begin
        state_next = st.i_is_r ? S_CO_NEXT : S_CO_RD;
      end
      S_CO_RD: begin
        cmd.csel   = stsolv_pkg::CS_C;
        state_next = S_CO_EV;
      end
      S_CO_EV: begin
        cmd.md_start = 1'b1;
        cmd.md_mode  = stsolv_pkg::MD_COL;
        state_next   = S_CO_WAIT;
      end
      S_CO_WAIT: begin
        cmd.csel = stsolv_pkg::CS_C;
        if (st.md_done) begin
          cmd.sol_we = 1'b1;
          state_next = S_CO_NEXT;
        end
      end
      S_CO_NEXT: begin
        if (st.i_end) begin
          cmd.j_clr  = 1'b1;
          state_next = S_RW_CHK;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_CO_CHK;
        end
      end
      S_RW_CHK: begin
        state_next = st.j_is_c ? S_RW_NEXT : S_RW_RD;
      end
      S_RW_RD: begin
        cmd.rsel   = stsolv_pkg::RS_R;
        state_next = S_RW_EV;
      end
      S_RW_EV: begin
        cmd.md_start = 1'b1;
        cmd.md_mode  = stsolv_pkg::MD_ROW;
        state_next   = S_RW_WAIT;
      end
      S_RW_WAIT: begin
        cmd.rsel = stsolv_pkg::RS_R;
        if (st.md_done) begin
          cmd.sol_we = 1'b1;
          state_next = S_RW_NEXT;
        end
      end
      S_RW_NEXT: begin
        if (st.j_end) begin
          state_next = S_PC_GO;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = S_RW_CHK;
        end
      end
      S_PC_GO: begin
        cmd.md_start = 1'b1;
        cmd.md_mode  = stsolv_pkg::MD_PIVOT;
        state_next   = S_PC_WAIT;
      end
      S_PC_WAIT: begin
        cmd.rsel = stsolv_pkg::RS_R;
        cmd.csel = stsolv_pkg::CS_C;
        if (st.md_done) begin
          cmd.sol_we   = 1'b1;
          cmd.lbl_swap = 1'b1;
          cmd.pc_inc   = 1'b1;
          state_next   = S_PC_CHK;
        end
      end
      S_PC_CHK: begin
        if (st.pc_hit) begin
          state_next = S_EMIT_LIM;
        end else begin
          cmd.ent_clr = 1'b1;
          state_next  = S_ENT_RD;
        end
      end
      S_OPT_J: begin
        cmd.opt_clr = 1'b1;
        cmd.i_clr   = 1'b1;
        state_next  = S_OPT_CHK;
      end
      S_OPT_CHK: begin
        if (st.i_end) begin
          state_next = S_OPT_EMIT;
        end else if (st.lbl_match) begin
          state_next = S_OPT_RD;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      S_OPT_RD: begin
        cmd.csel   = stsolv_pkg::CS_N;
        state_next = S_OPT_EV;
      end
      S_OPT_EV: begin
        cmd.opt_latch = 1'b1;
        cmd.i_inc     = 1'b1;
        state_next    = S_OPT_CHK;
      end
      S_OPT_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = stsolv_pkg::OK_VAR;
          if (st.j_last) begin
            state_next = S_Z_RD;
          end else begin
            cmd.j_inc  = 1'b1;
            state_next = S_OPT_J;
          end
        end
      end
      S_Z_RD: begin
        cmd.rsel   = stsolv_pkg::RS_M;
        cmd.csel   = stsolv_pkg::CS_N;
        state_next = S_Z_EV;
      end
      S_Z_EV: begin
        cmd.opt_latch = 1'b1;
        state_next    = S_Z_EMIT;
      end
      S_Z_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = stsolv_pkg::OK_Z;
          state_next   = S_IDLE;
        end
      end
      S_EMIT_UNB: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = stsolv_pkg::OK_UNB;
          state_next   = S_IDLE;
        end
      end
      S_EMIT_LIM: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = stsolv_pkg::OK_LIM;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/simplex_tableau_solver.sv -----
// ----------------------------------------------------------------------------
// simplex_tableau_solver
// Loading takes one entry beat per cycle while the entry channel is not
// stalled; a num_vars write realigns the load pointer, with the entry
// channel stalled. A pivot runs about (m+1)*(n+1) multiply-divides plus
// up to m for the ratio test. Up to n+1 result beats come per solve.
// Synchronous reset clears control and labels; tableau memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module simplex_tableau_solver (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               entry_valid,
  output      logic               entry_stall,
  input  wire logic signed [47:0] entry_value,
  input  wire logic               last_entry,
  output      logic               result_valid,
  input  wire logic               result_stall,
  output      logic [1:0]         status,
  output      logic [4:0]         var_index,
  output      logic signed [47:0] var_value,
  output      logic               last_result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  logic [stsolv_pkg::CNT_W-1:0] num_constraints;
  logic [stsolv_pkg::CNT_W-1:0] num_vars;
  logic [stsolv_pkg::PC_W-1:0]  max_pivots;
  stsolv_pkg::reg_idx_t         reg_idx;
  logic                         cfg_wr;
  logic [4:0]                   wr_val;
  logic [4:0]                   clamp_m;
  logic [4:0]                   clamp_n;
  logic                         nv_wr;
  stsolv_pkg::dp_cmd_t          cmd;
  stsolv_pkg::dp_stat_t         st;

  assign pready  = 1'b1;
  assign reg_idx = stsolv_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign wr_val  = pwdata[4:0];
  assign clamp_m = (wr_val == '0) ? 5'd1 :
                   (wr_val > 5'(stsolv_pkg::MAX_CONSTRAINTS)) ?
                   5'(stsolv_pkg::MAX_CONSTRAINTS) : wr_val;
  assign clamp_n = (wr_val == '0) ? 5'd1 :
                   (wr_val > 5'(stsolv_pkg::MAX_VARS)) ? 5'(stsolv_pkg::MAX_VARS) : wr_val;
  assign nv_wr   = cfg_wr && reg_idx == stsolv_pkg::REG_NUM_VARS;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_constraints <= 5'd1;
      num_vars        <= 5'd1;
      max_pivots      <= 6'd11;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        stsolv_pkg::REG_NUM_CONSTRAINTS: num_constraints <= clamp_m;
        stsolv_pkg::REG_NUM_VARS:        num_vars        <= clamp_n;
        stsolv_pkg::REG_MAX_PIVOTS:      max_pivots      <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      stsolv_pkg::REG_NUM_CONSTRAINTS: prdata = 32'(num_constraints);
      stsolv_pkg::REG_NUM_VARS:        prdata = 32'(num_vars);
      stsolv_pkg::REG_MAX_PIVOTS:      prdata = 32'(max_pivots);
      default:                         prdata = '0;
    endcase
  end

  stsolv_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  stsolv_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .m            (num_constraints),
    .n            (num_vars),
    .maxp         (max_pivots),
    .nv_wr        (nv_wr),
    .entry_valid  (entry_valid),
    .entry_stall  (entry_stall),
    .entry_value  (entry_value),
    .last_entry   (last_entry),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .var_index    (var_index),
    .var_value    (var_value),
    .last_result  (last_result)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/stsolv_checker.sv -----
// ----------------------------------------------------------------------------
// stsolv_checker
// Port-level checks on the result channel of the solver.
// ----------------------------------------------------------------------------
`default_nettype none

module stsolv_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire logic [1:0]         status,
  input wire logic [4:0]         var_index,
  input wire logic signed [47:0] var_value,
  input wire logic               last_result
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(var_value) && $stable(var_index))
    else $error("stalled result payload changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status <= stsolv_pkg::STATUS_LIMIT)
    else $error("illegal status code");

  a_status_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != stsolv_pkg::STATUS_OPTIMAL
      |-> last_result && var_index == 5'd0 && var_value == 48'sd0)
    else $error("status beat not a single zero beat");

endmodule

bind simplex_tableau_solver stsolv_checker u_stsolv_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .var_index    (var_index),
  .var_value    (var_value),
  .last_result  (last_result)
);

`default_nettype wire
